// File: src/framebuffer_line_rasterizer_top_defines.svh
// Assertion macros shared by the line rasterizer top level.
`ifndef FRAMEBUFFER_LINE_RASTERIZER_TOP_DEFINES_SVH
`define FRAMEBUFFER_LINE_RASTERIZER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fbr_pkg.sv
// Shared types, codes and constants of the frame buffer line rasterizer.
package fbr_pkg;

    // Default geometry of the frame store
    localparam int COLUMNS_DEFAULT = 128;
    localparam int PAGES_DEFAULT   = 8;

    // Reset value of the clear page count register
    localparam logic [3:0] CLEAR_PAGES_RESET = 4'd6;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Command codes on the func field
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_NOP,
        OP_LINE,
        OP_CLEAR,
        OP_READ
    } op_t;

    // One classified command, ready for the back end
    typedef struct packed {
        op_t        op;
        logic       erase;     // clear pixels instead of setting them
        logic       y_major;   // y is the stepping axis
        logic       sx_neg;    // x steps downward
        logic       sy_neg;    // y steps downward
        logic [7:0] x;         // first pixel column
        logic [7:0] y;         // first pixel row
        logic [7:0] dmaj;      // major axis distance (1 for straight lines)
        logic [7:0] dmin;      // minor axis distance (0 for straight lines)
        logic [8:0] count;     // pixels to visit
        logic [3:0] clr_n;     // pages to zero, already limited
        logic [2:0] rd_page;
        logic [6:0] rd_col;
        logic       rd_ok;     // read address lies inside the store
    } cmd_t;

    // Back end status seen by the front end
    typedef struct packed {
        logic init_done;       // power-up clearing pass finished
    } bk_status_t;

endpackage

// File: src/framebuffer_line_rasterizer_top.sv
// Line rasterizer over a paged monochrome frame store (PAGES x COLUMNS bytes, one
// bit per vertical pixel). Every command transaction returns exactly one read_data
// transaction, in order: the stored byte for an in-range read, zero otherwise. Commands
// enter a two-entry queue and are carried out one at a time by the back end, whose
// speed is set by the single frame-store write port: a line is set up and then visits
// its pixels one after another (up to 256 for a straight line), and a clear zeroes
// n*COLUMNS bytes at one byte per cycle, where n is clear_pages limited to PAGES (a
// zero count zeroes nothing). After reset the store is swept to zero, PAGES*COLUMNS
// bytes (1024 by default), during which in_ready stays low; the configuration
// channel is always ready.
`include "framebuffer_line_rasterizer_top_defines.svh"

module framebuffer_line_rasterizer_top
    import fbr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int PAGES   = PAGES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] x_start,
    input  logic [7:0] y_start,
    input  logic [7:0] x_end,
    input  logic [7:0] y_end,
    input  logic       color,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    bk_status_t bk_status;
    cmd_t       push_cmd;
    cmd_t       head;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    // Command intake and classification
    fbr_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .color       (color),
        .read_page   (read_page),
        .read_column (read_column),
        .status      (bk_status),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    // Decoupling queue
    fbr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Execution and frame store
    fbr_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .status    (bk_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data)
    );

    // Checks
    `FBR_ASSERT_NOW(a_quiet_in_init, !bk_status.init_done, !out_valid && !in_ready, "init busy")
    `FBR_ASSERT_NEXT(a_accept_lands_in_queue, in_valid && in_ready, !q_empty, "lost transaction")
    `FBR_ASSERT_NOW(a_no_pop_when_empty, q_empty, !pop, "back end popped an empty queue")

endmodule

// File: src/fbr_front.sv
// Front end: input and configuration handshakes, command classification and line setup.
module fbr_front
    import fbr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int PAGES   = PAGES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] x_start,
    input  logic [7:0] y_start,
    input  logic [7:0] x_end,
    input  logic [7:0] y_end,
    input  logic       color,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,
    input  bk_status_t status,
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    logic [3:0] clear_pages_reg;
    logic       dx_neg;
    logic       dy_neg;
    logic [7:0] dx_abs;
    logic [7:0] dy_abs;
    logic       y_major;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pages_reg <= CLEAR_PAGES_RESET;
        end
        else if (cfg_valid)
        begin
            clear_pages_reg <= cfg_data;
        end
    end

    // Hold off input during the power-up clear or while the queue is full
    assign in_ready = status.init_done && !q_full;
    assign push     = in_valid && in_ready;

    // Line distances and directions
    assign dx_neg  = x_end < x_start;
    assign dy_neg  = y_end < y_start;
    assign dx_abs  = dx_neg ? (x_start - x_end) : (x_end - x_start);
    assign dy_abs  = dy_neg ? (y_start - y_end) : (y_end - y_start);
    assign y_major = !(dx_abs > dy_abs);

    // Classify the transaction into a queue entry
    always_comb
    begin
        cmd         = '0;
        cmd.erase   = color;
        cmd.rd_page = read_page;
        cmd.rd_col  = read_column;
        cmd.rd_ok   = (32'(read_page) < PAGES) && (32'(read_column) < COLUMNS);
        if (32'(clear_pages_reg) > PAGES)
        begin
            cmd.clr_n = 4'(PAGES);
        end
        else
        begin
            cmd.clr_n = clear_pages_reg;
        end
        case (func)
            FUNC_DRAW:
            begin
                cmd.op = OP_LINE;
                if (x_start == x_end)
                begin
                    // vertical, both end points, walk upward from the lower row
                    cmd.x       = x_start;
                    cmd.y       = dy_neg ? y_end : y_start;
                    cmd.y_major = 1'b1;
                    cmd.dmaj    = 8'd1;
                    cmd.dmin    = 8'd0;
                    cmd.count   = {1'b0, dy_abs} + 9'd1;
                end
                else if (y_start == y_end)
                begin
                    // horizontal, both end points
                    cmd.x       = dx_neg ? x_end : x_start;
                    cmd.y       = y_start;
                    cmd.y_major = 1'b0;
                    cmd.dmaj    = 8'd1;
                    cmd.dmin    = 8'd0;
                    cmd.count   = {1'b0, dx_abs} + 9'd1;
                end
                else
                begin
                    // sloped, end point excluded
                    cmd.x       = x_start;
                    cmd.y       = y_start;
                    cmd.sx_neg  = dx_neg;
                    cmd.sy_neg  = dy_neg;
                    cmd.y_major = y_major;
                    cmd.dmaj    = y_major ? dy_abs : dx_abs;
                    cmd.dmin    = y_major ? dx_abs : dy_abs;
                    cmd.count   = {1'b0, (y_major ? dy_abs : dx_abs)};
                end
            end
            FUNC_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            FUNC_READ:
            begin
                cmd.op = OP_READ;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

// File: src/fbr_queue.sv
// Short command queue between the front end and the back end.
module fbr_queue
    import fbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/fbr_back.sv
// Back end: frame store, pixel stepping, read-modify-write, clear sweeps and result register.
module fbr_back
    import fbr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int PAGES   = PAGES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       q_empty,
    output logic       pop,
    output bk_status_t status,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = 8 * PAGES;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINE,
        S_CLEAR,
        S_READ
    } state_t;

    // frame store
    logic [7:0]  mem [DEPTH];
    logic [7:0]  mem_q;
    logic [AW-1:0] rd_addr;
    logic        we;
    logic [AW-1:0] waddr;
    logic [7:0]  wdata;

    // control and datapath registers
    state_t      state_reg, state_next;
    logic        init_done_reg, init_done_next;
    logic [AW:0] clr_cnt_reg, clr_cnt_next;
    logic [AW:0] clr_end_reg, clr_end_next;
    logic [7:0]  lx_reg, lx_next;
    logic [7:0]  ly_reg, ly_next;
    logic [8:0]  lcnt_reg, lcnt_next;
    logic signed [10:0] err_reg, err_next;
    logic [7:0]  dmaj_reg, dmaj_next;
    logic [7:0]  dmin_reg, dmin_next;
    logic        ymaj_reg, ymaj_next;
    logic        sxn_reg, sxn_next;
    logic        syn_reg, syn_next;
    logic        erase_reg, erase_next;
    logic        rd_ok_reg, rd_ok_next;
    logic        b_valid_reg, b_valid_next;
    logic [AW-1:0] b_addr_reg;
    logic [7:0]  b_mask_reg;
    logic        b_erase_reg;
    logic        wl_valid_reg;
    logic [AW-1:0] wl_addr_reg;
    logic [7:0]  wl_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_data_reg, read_data_next;

    // combinational helpers
    logic        out_free;
    logic        onscreen;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] cmd_addr;
    logic [7:0]  pix_mask;
    logic [7:0]  base;
    logic [7:0]  merged;
    logic signed [10:0] err_add;
    logic signed [11:0] err2;
    logic        take;
    logic [7:0]  x_step;
    logic [7:0]  y_step;

    assign status.init_done = init_done_reg;
    assign out_valid        = out_valid_reg;
    assign read_data        = read_data_reg;
    assign out_free         = !out_valid_reg || out_ready;

    // Current pixel address and mask
    assign onscreen = (32'(lx_reg) < COLUMNS) && (32'(ly_reg) < ROWS);
    assign pix_addr = AW'(32'(ly_reg[7:3]) * COLUMNS + 32'(lx_reg));
    assign pix_mask = 8'b1 << ly_reg[2:0];
    assign cmd_addr = AW'(32'(head.rd_page) * COLUMNS + 32'(head.rd_col));

    // Bresenham decision for the next pixel
    assign err_add = err_reg + $signed({3'b000, dmin_reg});
    assign err2    = {err_add, 1'b0};
    assign take    = err2 >= $signed({4'b0000, dmaj_reg});
    assign x_step  = sxn_reg ? (lx_reg - 8'd1) : (lx_reg + 8'd1);
    assign y_step  = syn_reg ? (ly_reg - 8'd1) : (ly_reg + 8'd1);

    // Read address: the waiting read command in idle, else the current pixel
    assign rd_addr = (state_reg == S_IDLE && head.op == OP_READ) ? cmd_addr : pix_addr;

    // Forward the byte written last cycle, its read saw the old value
    assign base   = (wl_valid_reg && wl_addr_reg == b_addr_reg) ? wl_data_reg : mem_q;
    assign merged = b_erase_reg ? (base & ~b_mask_reg) : (base | b_mask_reg);

    // Single write port: pixel update or clear sweep
    assign we    = b_valid_reg || (state_reg == S_CLEAR);
    assign waddr = b_valid_reg ? b_addr_reg : clr_cnt_reg[AW-1:0];
    assign wdata = b_valid_reg ? merged : 8'h00;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q <= mem[rd_addr];
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        init_done_next = init_done_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_end_next   = clr_end_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        lcnt_next      = lcnt_reg;
        err_next       = err_reg;
        dmaj_next      = dmaj_reg;
        dmin_next      = dmin_reg;
        ymaj_next      = ymaj_reg;
        sxn_next       = sxn_reg;
        syn_next       = syn_reg;
        erase_next     = erase_reg;
        rd_ok_next     = rd_ok_reg;
        b_valid_next   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        read_data_next = read_data_reg;
        pop            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    pop = 1'b1;
                    if (head.op != OP_READ)
                    begin
                        // non-read commands answer zero right away
                        out_valid_next = 1'b1;
                        read_data_next = 8'h00;
                    end
                    case (head.op)
                        OP_LINE:
                        begin
                            lx_next    = head.x;
                            ly_next    = head.y;
                            lcnt_next  = head.count;
                            err_next   = '0;
                            dmaj_next  = head.dmaj;
                            dmin_next  = head.dmin;
                            ymaj_next  = head.y_major;
                            sxn_next   = head.sx_neg;
                            syn_next   = head.sy_neg;
                            erase_next = head.erase;
                            state_next = S_LINE;
                        end
                        OP_CLEAR:
                        begin
                            if (head.clr_n != 4'd0)
                            begin
                                clr_cnt_next = '0;
                                clr_end_next = (AW + 1)'(32'(head.clr_n) * COLUMNS);
                                state_next   = S_CLEAR;
                            end
                        end
                        OP_READ:
                        begin
                            rd_ok_next = head.rd_ok;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LINE:
            begin
                // plot current pixel, then step along the major axis
                b_valid_next = onscreen;
                lcnt_next    = lcnt_reg - 9'd1;
                err_next     = take ? (err_add - $signed({3'b000, dmaj_reg})) : err_add;
                if (ymaj_reg)
                begin
                    ly_next = y_step;
                    if (take)
                    begin
                        lx_next = x_step;
                    end
                end
                else
                begin
                    lx_next = x_step;
                    if (take)
                    begin
                        ly_next = y_step;
                    end
                end
                if (lcnt_reg == 9'd1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == clr_end_reg - 1'b1)
                begin
                    init_done_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                read_data_next = rd_ok_reg ? base : 8'h00;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; reset starts a full clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_done_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            clr_end_reg   <= (AW + 1)'(DEPTH);
            lcnt_reg      <= '0;
            b_valid_reg   <= 1'b0;
            wl_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_done_reg <= init_done_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_end_reg   <= clr_end_next;
            lcnt_reg      <= lcnt_next;
            b_valid_reg   <= b_valid_next;
            wl_valid_reg  <= we;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lx_reg        <= lx_next;
        ly_reg        <= ly_next;
        err_reg       <= err_next;
        dmaj_reg      <= dmaj_next;
        dmin_reg      <= dmin_next;
        ymaj_reg      <= ymaj_next;
        sxn_reg       <= sxn_next;
        syn_reg       <= syn_next;
        erase_reg     <= erase_next;
        rd_ok_reg     <= rd_ok_next;
        b_addr_reg    <= rd_addr;
        b_mask_reg    <= pix_mask;
        b_erase_reg   <= erase_reg;
        wl_addr_reg   <= waddr;
        wl_data_reg   <= wdata;
        read_data_reg <= read_data_next;
    end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the line rasterizer: directed and random commands.
module testbench;
    import fbr_pkg::*;

    localparam int COLS          = COLUMNS_DEFAULT;
    localparam int NPAGES        = PAGES_DEFAULT;
    localparam int ROWS          = 8 * NPAGES;
    localparam int SETTLE_CYCLES = 1100;   // longest back-end job plus margin
    localparam int HOLD_CYCLES   = 1500;   // long receiver hold-off
    localparam int PHASE_HALF    = 150;    // items per half phase
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic       color;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } raster_cmd_t;

    // Clock and DUT ports
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] func = '0;
    logic [7:0] x_start = '0;
    logic [7:0] y_start = '0;
    logic [7:0] x_end = '0;
    logic [7:0] y_end = '0;
    logic       color = 1'b0;
    logic [2:0] read_page = '0;
    logic [6:0] read_column = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;

    // Shadow frame store and register
    logic [7:0]  frame_bytes [NPAGES*COLS];
    logic [3:0]  shadow_clear_pages = CLEAR_PAGES_RESET;

    // Command backlog and results still owed by the DUT
    raster_cmd_t cmd_backlog [$];
    logic [7:0]  read_data_due [$];

    // Handshake bookkeeping
    raster_cmd_t cur_cmd;
    raster_cmd_t seen_cmd;
    bit          in_done = 1'b0;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;
    int          calm_in = 0;
    int          calm_out = 0;
    int          n_accepted = 0;
    int          hold_left = 0;
    int          hold_mark = 40;
    int          mismatch_count = 0;
    int          result_count = 0;
    int          last_col = 0;
    int          last_row = 0;
    logic [7:0]  want;

    framebuffer_line_rasterizer_top #(
        .COLUMNS(COLS),
        .PAGES  (NPAGES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .color      (color),
        .read_page  (read_page),
        .read_column(read_column),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- frame model ----------------

    function automatic void plot_pixel(int x, int y, bit erase);
        int         idx;
        logic [7:0] mask;
        if (x < 0 || y < 0 || x >= COLS || y >= ROWS)
            return;
        idx  = (y / 8) * COLS + x;
        mask = 8'h01 << (y % 8);
        if (erase)
            frame_bytes[idx] = frame_bytes[idx] & ~mask;
        else
            frame_bytes[idx] = frame_bytes[idx] | mask;
    endfunction

    // Straight lines include both ends; sloped lines stop one short of the end
    function automatic void trace_line(int xa, int ya, int xb, int yb, bit erase);
        int lo, hi, i, dx, dy, sx, sy, x, y, err;
        if (xa == xb)
        begin
            lo = (ya < yb) ? ya : yb;
            hi = (ya < yb) ? yb : ya;
            for (i = lo; i <= hi; i++)
                plot_pixel(xa, i, erase);
        end
        else if (ya == yb)
        begin
            lo = (xa < xb) ? xa : xb;
            hi = (xa < xb) ? xb : xa;
            for (i = lo; i <= hi; i++)
                plot_pixel(i, ya, erase);
        end
        else
        begin
            dx  = xb - xa;
            dy  = yb - ya;
            sx  = (dx > 0) ? 1 : -1;
            sy  = (dy > 0) ? 1 : -1;
            x   = xa;
            y   = ya;
            err = 0;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > dy)
            begin
                for (; x != xb; x += sx)
                begin
                    plot_pixel(x, y, erase);
                    err += dy;
                    if (err * 2 >= dx)
                    begin
                        y   += sy;
                        err -= dx;
                    end
                end
            end
            else
            begin
                // equal distances step along y
                for (; y != yb; y += sy)
                begin
                    plot_pixel(x, y, erase);
                    err += dx;
                    if (err * 2 >= dy)
                    begin
                        x   += sx;
                        err -= dy;
                    end
                end
            end
        end
    endfunction

    // Apply one command to the shadow store, return the byte the DUT should send back
    function automatic logic [7:0] rasterize_cmd(raster_cmd_t c);
        int n;
        logic [7:0] data;
        data = 8'h00;
        case (c.func)
            FUNC_DRAW:
                trace_line(c.x_start, c.y_start, c.x_end, c.y_end, c.color);
            FUNC_CLEAR:
            begin
                n = (shadow_clear_pages > NPAGES) ? NPAGES : shadow_clear_pages;
                for (int i = 0; i < n * COLS; i++)
                    frame_bytes[i] = 8'h00;
            end
            FUNC_READ:
                if (c.read_page < NPAGES && c.read_column < COLS)
                    data = frame_bytes[c.read_page * COLS + c.read_column];
            default: ;
        endcase
        return data;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic raster_cmd_t make_cmd(logic [1:0] f, int xs, int ys, int xe, int ye,
                                             bit col, int pg, int cl);
        raster_cmd_t c;
        c.func        = f;
        c.x_start     = xs[7:0];
        c.y_start     = ys[7:0];
        c.x_end       = xe[7:0];
        c.y_end       = ye[7:0];
        c.color       = col;
        c.read_page   = pg[2:0];
        c.read_column = cl[6:0];
        return c;
    endfunction

    // Point near base, clamped to the coordinate range
    function automatic logic [7:0] near(int base, int span);
        int v;
        v = base + $urandom_range(2 * span) - span;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic raster_cmd_t rand_cmd();
        raster_cmd_t c;
        int r, kind, v;
        // don't-care fields are random too
        c.func        = 2'($urandom_range(3));
        c.x_start     = 8'($urandom_range(255));
        c.y_start     = 8'($urandom_range(255));
        c.x_end       = 8'($urandom_range(255));
        c.y_end       = 8'($urandom_range(255));
        c.color       = 1'($urandom_range(1));
        c.read_page   = 3'($urandom_range(7));
        c.read_column = 7'($urandom_range(127));
        r = $urandom_range(99);
        if (r < 45)
        begin
            c.func    = FUNC_DRAW;
            c.x_start = 8'($urandom_range(135));
            c.y_start = 8'($urandom_range(70));
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                c.x_end = c.x_start;
                c.y_end = near(c.y_start, 40);
            end
            else if (kind == 1)
            begin
                c.y_end = c.y_start;
                c.x_end = near(c.x_start, 60);
            end
            else if (kind <= 6)
            begin
                c.x_end = near(c.x_start, 12);
                c.y_end = near(c.y_start, 12);
            end
            else if (kind <= 8)
            begin
                c.x_end = 8'($urandom_range(135));
                c.y_end = 8'($urandom_range(70));
            end
            else
            begin
                c.x_start = 8'($urandom_range(255));
                c.y_start = 8'($urandom_range(255));
            end
            c.color  = ($urandom_range(99) < 30);
            last_col = int'(c.x_start);
            last_row = int'(c.y_start);
        end
        else if (r < 50)
            c.func = FUNC_CLEAR;
        else if (r < 96)
        begin
            c.func = FUNC_READ;
            // most reads land where drawing just happened
            if ($urandom_range(9) < 6)
            begin
                if (last_row < ROWS)
                    c.read_page = 3'(last_row / 8);
                v = (last_col + $urandom_range(6) - 3) & 127;
                c.read_column = v[6:0];
            end
        end
        else
            c.func = FUNC_UNUSED;
        return c;
    endfunction

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || in_valid || read_data_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_clear_pages(logic [3:0] value);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_clear_pages = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- driver ----------------

    // Record accepted commands and predict their results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            seen_cmd.func        = func;
            seen_cmd.x_start     = x_start;
            seen_cmd.y_start     = y_start;
            seen_cmd.x_end       = x_end;
            seen_cmd.y_end       = y_end;
            seen_cmd.color       = color;
            seen_cmd.read_page   = read_page;
            seen_cmd.read_column = read_column;
            read_data_due.push_back(rasterize_cmd(seen_cmd));
            n_accepted <= n_accepted + 1;
            in_done = 1'b1;
        end
    end

    // Present the next command, with random gaps and calm stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm_in > 0)
                calm_in--;
            else if ($urandom_range(199) == 0)
                calm_in = $urandom_range(20, 80);
            if (!in_valid || in_done)
            begin
                in_done = 1'b0;
                if (cmd_backlog.size() != 0 &&
                    (calm_in != 0 || $urandom_range(99) >= in_idle_pct))
                begin
                    cur_cmd      = cmd_backlog.pop_front();
                    in_valid    <= 1'b1;
                    func        <= cur_cmd.func;
                    x_start     <= cur_cmd.x_start;
                    y_start     <= cur_cmd.y_start;
                    x_end       <= cur_cmd.x_end;
                    y_end       <= cur_cmd.y_end;
                    color       <= cur_cmd.color;
                    read_page   <= cur_cmd.read_page;
                    read_column <= cur_cmd.read_column;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    // Long hold-off on the result side, armed by progress on the input side
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (rst_n && n_accepted >= hold_mark)
        begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= hold_mark + 900;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm_out > 0)
                calm_out--;
            else if ($urandom_range(199) == 0)
                calm_out = $urandom_range(20, 80);
            out_ready <= (hold_left == 0) &&
                         (calm_out != 0 || $urandom_range(99) >= out_stall_pct);
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (read_data_due.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("result %0d: read_data %02h with no transaction outstanding",
                             result_count, read_data);
                mismatch_count++;
            end
            else
            begin
                want = read_data_due.pop_front();
                if (read_data !== want)
                begin
                    if (mismatch_count < 10)
                        $display("result %0d: read_data expected %02h, got %02h",
                                 result_count, want, read_data);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        logic [3:0] cfg_values [6];
        cfg_values = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd0, 4'd3};
        cfg_values[4] = 4'($urandom_range(15));
        for (int i = 0; i < NPAGES * COLS; i++)
            frame_bytes[i] = 8'h00;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, register at its reset value
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        // horizontal full width, ends given high to low
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 127, 0, 0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 127));
        // vertical full height, bottom to top
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 5, 63, 5, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 7, 5));
        // single pixel
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 10, 10, 10, 10, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 1, 10));
        // equal distances, end pixel left out
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 20, 0, 28, 8, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 1, 28));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 20));
        // shallow slope, then a diagonal running backward on both axes
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 30, 0, 60, 5, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 100, 50, 90, 40, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 5, 95));
        // partly and fully off the screen
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 120, 60, 255, 255, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 0, 200, 255, 200, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 255, 0, 0, 63, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 7, 127));
        // erase part of the top row
        cmd_backlog.push_back(make_cmd(FUNC_DRAW, 0, 0, 63, 0, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        // clear the leading pages, the vertical line survives below them
        cmd_backlog.push_back(make_cmd(FUNC_CLEAR, 255, 255, 255, 255, 1, 7, 127));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 5, 5));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 6, 5));
        // unused command
        cmd_backlog.push_back(make_cmd(FUNC_UNUSED, 255, 255, 255, 255, 1, 7, 127));
        cmd_backlog.push_back(make_cmd(FUNC_READ, 255, 255, 255, 255, 1, 7, 5));
        wait_drained();

        // Random phases, one register setting and one idling pattern each
        for (int ph = 0; ph < 6; ph++)
        begin
            write_clear_pages(cfg_values[ph]);
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 64; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 64; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            // sender pauses in the middle until everything has come back
            for (int h = 0; h < 2; h++)
            begin
                for (int k = 0; k < PHASE_HALF; k++)
                    cmd_backlog.push_back(rand_cmd());
                wait_drained();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && read_data_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #250000000;
        $display("status: fail");
        $finish;
    end

endmodule
